@@ rtl/usp_pkg.sv @@
// Shared types and constants for the UTF-8 sanitizer.
// Holds the command word passed from the classifier to the byte emitter.
// No dependencies.
package usp_pkg;

  // Reset value of the scalar limit register
  localparam logic [15:0] MAX_SCALARS_RESET = 16'd20;

  // Default number of command entries between classifier and emitter
  localparam int unsigned QUEUE_DEPTH = 2;

  // Replacement character U+FFFD as UTF-8
  localparam logic [7:0] REP_BYTE0 = 8'hEF;
  localparam logic [7:0] REP_BYTE1 = 8'hBF;
  localparam logic [7:0] REP_BYTE2 = 8'hBD;

  // Code point bounds used by the well-formedness check
  localparam logic [4:0]  SURR_TOP5 = 5'b11011;     // 0xD800..0xDFFF share these bits
  localparam logic [20:0] CP_MAX    = 21'h10FFFF;

  // Work for one input word, emitted in field order:
  // replacements, pass-through bytes, tail replacements, end marker.
  typedef struct packed {
    logic [2:0]      rep_pre;
    logic [2:0]      pass_len;
    logic [3:0][7:0] pass_bytes;
    logic [1:0]      rep_post;
    logic            marker;
    logic            trunc;
  } cmd_t;

endpackage

@@ rtl/usp_front.sv @@
// Classifier: accepts input bytes, tracks pending sequences and the scalar
// limit, and turns each input word into one command for the emitter.
// Depends on usp_pkg.
module usp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,
  input  logic              s_axis_tlast,
  input  logic [15:0]       max_scalars_i,
  output logic              push_o,
  output usp_pkg::cmd_t     cmd_o,
  input  logic              full_i
);

  logic [7:0]  held_q [3];
  logic [7:0]  held_d [3];
  logic [1:0]  held_cnt_q, held_cnt_d;
  logic [2:0]  exp_len_q, exp_len_d;
  logic [15:0] scal_cnt_q, scal_cnt_d;
  logic        limit_q, limit_d;

  logic        accept;
  logic        is_cont;
  logic [2:0]  lead_len;
  logic [15:0] diff;
  logic [2:0]  avail;
  logic [2:0]  total;
  logic [3:0][7:0] seq;
  logic [15:0] cp3;
  logic [20:0] cp4;
  logic        seq_ok;
  logic        hit;
  logic        begin_req;
  logic [2:0]  used;
  logic [2:0]  k;
  logic [2:0]  rem;
  logic [2:0]  inc;
  usp_pkg::cmd_t cmd;

  assign s_axis_tready = !full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_cont       = (s_axis_tdata[7:6] == 2'b10);
  assign total         = {1'b0, held_cnt_q} + 3'd1;

  // Classify the lead byte by its prefix
  always_comb begin
    if (!s_axis_tdata[7])                      lead_len = 3'd1;
    else if (s_axis_tdata[7:5] == 3'b110)      lead_len = 3'd2;
    else if (s_axis_tdata[7:4] == 4'b1110)     lead_len = 3'd3;
    else if (s_axis_tdata[7:3] == 5'b11110)    lead_len = 3'd4;
    else                                       lead_len = 3'd0;
  end

  // Scalars still allowed, saturated; one word never needs more than five
  assign diff  = max_scalars_i - scal_cnt_q;
  assign avail = (scal_cnt_q >= max_scalars_i) ? 3'd0 :
                 ((diff > 16'd7) ? 3'd7 : diff[2:0]);

  // Assemble the completed sequence: held bytes, then the new byte
  assign seq[0] = held_q[0];
  assign seq[1] = (held_cnt_q == 2'd1) ? s_axis_tdata : held_q[1];
  assign seq[2] = (held_cnt_q == 2'd2) ? s_axis_tdata :
                  ((held_cnt_q == 2'd3) ? held_q[2] : 8'd0);
  assign seq[3] = (held_cnt_q == 2'd3) ? s_axis_tdata : 8'd0;

  // Reject overlong forms, surrogates and values past the last plane
  assign cp3 = {seq[0][3:0], seq[1][5:0], seq[2][5:0]};
  assign cp4 = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};
  always_comb begin
    case (exp_len_q)
      3'd2:    seq_ok = (seq[0][4:1] != 4'd0);
      3'd3:    seq_ok = (cp3[15:11] != 5'd0) && (cp3[15:11] != usp_pkg::SURR_TOP5);
      3'd4:    seq_ok = (cp4[20:16] != 5'd0) && (cp4 <= usp_pkg::CP_MAX);
      default: seq_ok = 1'b0;
    endcase
  end

  // Build the command and the next state for the incoming word
  always_comb begin
    cmd          = '0;
    hit          = 1'b0;
    used         = 3'd0;
    k            = 3'd0;
    rem          = 3'd0;
    begin_req    = 1'b0;
    held_cnt_d   = held_cnt_q;
    exp_len_d    = exp_len_q;
    held_d       = held_q;

    if (limit_q) begin
      // drop everything until the end of the text
    end else if (held_cnt_q == 2'd0) begin
      begin_req = 1'b1;
    end else if (!is_cont) begin
      // broken sequence: replace each held byte, then restart
      k = {1'b0, held_cnt_q};
      if (k > avail) begin
        cmd.rep_pre = avail;
        hit         = 1'b1;
      end else begin
        cmd.rep_pre = k;
      end
      used       = cmd.rep_pre;
      held_cnt_d = 2'd0;
      exp_len_d  = 3'd0;
      begin_req  = !hit;
    end else if (total >= exp_len_q) begin
      held_cnt_d = 2'd0;
      exp_len_d  = 3'd0;
      if (seq_ok) begin
        cmd.pass_len   = total;
        cmd.pass_bytes = seq;
      end else begin
        if (total > avail) begin
          cmd.rep_pre = avail;
          hit         = 1'b1;
        end else begin
          cmd.rep_pre = total;
        end
        used = cmd.rep_pre;
      end
    end else if (held_cnt_q != 2'd3) begin
      held_d[held_cnt_q] = s_axis_tdata;
      held_cnt_d         = held_cnt_q + 2'd1;
    end

    // start a new scalar from this byte
    if (begin_req) begin
      if (used == avail) begin
        hit = 1'b1;
      end else begin
        case (lead_len)
          3'd1: begin
            cmd.pass_len      = 3'd1;
            cmd.pass_bytes[0] = s_axis_tdata;
            used              = used + 3'd1;
          end
          3'd0: begin
            cmd.rep_pre = cmd.rep_pre + 3'd1;
            used        = used + 3'd1;
          end
          default: begin
            held_d[0]  = s_axis_tdata;
            held_cnt_d = 2'd1;
            exp_len_d  = lead_len;
          end
        endcase
      end
    end

    // flush an incomplete tail and close the text
    if (s_axis_tlast) begin
      if ((held_cnt_d != 2'd0) && !hit && !limit_q) begin
        k   = {1'b0, held_cnt_d};
        rem = avail - used;
        if (k > rem) begin
          cmd.rep_post = rem[1:0];
          hit          = 1'b1;
        end else begin
          cmd.rep_post = held_cnt_d;
        end
      end
      cmd.marker = 1'b1;
      cmd.trunc  = hit || limit_q;
    end

    inc = cmd.rep_pre + {1'b0, cmd.rep_post} + {2'd0, (cmd.pass_len != 3'd0)};

    if (s_axis_tlast) begin
      held_cnt_d = 2'd0;
      exp_len_d  = 3'd0;
      scal_cnt_d = 16'd0;
      limit_d    = 1'b0;
    end else begin
      scal_cnt_d = scal_cnt_q + 16'(inc);
      limit_d    = limit_q || hit;
    end
  end

  assign cmd_o  = cmd;
  assign push_o = accept && ((cmd.rep_pre != 3'd0) || (cmd.pass_len != 3'd0) ||
                             (cmd.rep_post != 2'd0) || cmd.marker);

  // Sequence and limit state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= 2'd0;
      exp_len_q  <= 3'd0;
      scal_cnt_q <= 16'd0;
      limit_q    <= 1'b0;
    end else if (accept) begin
      held_cnt_q <= held_cnt_d;
      exp_len_q  <= exp_len_d;
      scal_cnt_q <= scal_cnt_d;
      limit_q    <= limit_d;
    end
  end

  // Held bytes of a pending sequence
  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

`ifndef SYNTH
  a_eot_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tlast) |=> (held_cnt_q == 2'd0 && !limit_q && scal_cnt_q == 16'd0))
    else $error("state not cleared after end of text");

  a_pending_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_cnt_q != 2'd0) |-> (exp_len_q > {1'b0, held_cnt_q}))
    else $error("pending sequence longer than its lead allows");
`endif

endmodule

@@ rtl/usp_fifo.sv @@
// Command queue between classifier and emitter, built from flip-flops.
// Depends on usp_pkg for the command type.
module usp_fifo #(
  parameter int unsigned DEPTH = usp_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  usp_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output usp_pkg::cmd_t head_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  usp_pkg::cmd_t  mem_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  count_q;

  assign full_o       = (count_q == CW'(DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("pop from empty queue");
`endif

endmodule

@@ rtl/usp_back.sv @@
// Emitter: walks the command at the queue head and sends one output word per
// cycle through a registered output stage while the receiver is ready.
// Depends on usp_pkg.
module usp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  usp_pkg::cmd_t head_i,
  output logic          pop_o,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [7:0]    m_axis_tdata,
  output logic          m_axis_tlast,
  output logic [1:0]    m_axis_tuser
);

  typedef enum logic [4:0] {
    PH_REPB = 5'b00001,
    PH_PASS = 5'b00010,
    PH_REPA = 5'b00100,
    PH_MARK = 5'b01000,
    PH_DONE = 5'b10000
  } phase_e;

  // First phase at or after the given one that has work in this command
  function automatic phase_e first_phase(usp_pkg::cmd_t c, phase_e from);
    phase_e ph;
    ph = from;
    if (ph == PH_REPB && c.rep_pre == 3'd0)  ph = PH_PASS;
    if (ph == PH_PASS && c.pass_len == 3'd0) ph = PH_REPA;
    if (ph == PH_REPA && c.rep_post == 2'd0) ph = PH_MARK;
    if (ph == PH_MARK && !c.marker)          ph = PH_DONE;
    return ph;
  endfunction

  phase_e      phase_q, phase_d, eph, nph;
  logic        fresh_q, fresh_d;
  logic [2:0]  cnt_q, cnt_d, ecnt, cnt_inc;
  logic [1:0]  tri_q, tri_d, etri;
  logic        slot_free, emit;
  logic [7:0]  item_byte;
  logic        item_valid, item_last, item_trunc;
  logic [7:0]  rep_byte;

  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;
  logic [1:0]  out_user_q;

  assign slot_free = !out_valid_q || m_axis_tready;
  assign emit      = head_valid_i && slot_free;

  assign eph     = fresh_q ? first_phase(head_i, PH_REPB) : phase_q;
  assign ecnt    = fresh_q ? 3'd0 : cnt_q;
  assign etri    = fresh_q ? 2'd0 : tri_q;
  assign cnt_inc = ecnt + 3'd1;

  always_comb begin
    case (etri)
      2'd0:    rep_byte = usp_pkg::REP_BYTE0;
      2'd1:    rep_byte = usp_pkg::REP_BYTE1;
      default: rep_byte = usp_pkg::REP_BYTE2;
    endcase
  end

  // Pick the current output word and step through the command
  always_comb begin
    nph        = eph;
    cnt_d      = ecnt;
    tri_d      = etri;
    item_byte  = 8'd0;
    item_valid = 1'b0;
    item_last  = 1'b0;
    item_trunc = 1'b0;
    unique case (eph)
      PH_REPB: begin
        item_byte  = rep_byte;
        item_valid = 1'b1;
        if (etri == 2'd2) begin
          tri_d = 2'd0;
          if (cnt_inc == head_i.rep_pre) begin
            cnt_d = 3'd0;
            nph   = first_phase(head_i, PH_PASS);
          end else begin
            cnt_d = cnt_inc;
          end
        end else begin
          tri_d = etri + 2'd1;
        end
      end
      PH_PASS: begin
        item_byte  = head_i.pass_bytes[ecnt[1:0]];
        item_valid = 1'b1;
        if (cnt_inc == head_i.pass_len) begin
          cnt_d = 3'd0;
          nph   = first_phase(head_i, PH_REPA);
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_REPA: begin
        item_byte  = rep_byte;
        item_valid = 1'b1;
        if (etri == 2'd2) begin
          tri_d = 2'd0;
          if (cnt_inc == {1'b0, head_i.rep_post}) begin
            cnt_d = 3'd0;
            nph   = first_phase(head_i, PH_MARK);
          end else begin
            cnt_d = cnt_inc;
          end
        end else begin
          tri_d = etri + 2'd1;
        end
      end
      PH_MARK: begin
        item_last  = 1'b1;
        item_trunc = head_i.trunc;
        nph        = PH_DONE;
      end
      PH_DONE: begin
        nph = PH_DONE;
      end
      default: begin
        nph = PH_DONE;
      end
    endcase
  end

  assign pop_o   = emit && (nph == PH_DONE);
  assign fresh_d = pop_o ? 1'b1 : (emit ? 1'b0 : fresh_q);
  assign phase_d = emit ? nph : phase_q;

  // Command walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= 1'b1;
      phase_q <= PH_REPB;
      cnt_q   <= 3'd0;
      tri_q   <= 2'd0;
    end else begin
      fresh_q <= fresh_d;
      phase_q <= phase_d;
      if (emit) begin
        cnt_q <= cnt_d;
        tri_q <= tri_d;
      end
    end
  end

  // Output stage: load a new word when the slot is free, drop it when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= item_byte;
      out_last_q <= item_last;
      out_user_q <= {item_trunc, item_valid};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_user_q;

`ifndef SYNTH
  a_marker_bare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (!m_axis_tuser[0] && m_axis_tdata == 8'd0))
    else $error("end marker carries data");

  a_fresh_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> fresh_q)
    else $error("command walk not restarted after pop");
`endif

endmodule

@@ rtl/utf8_sanitize_prefix.sv @@
// UTF-8 sanitizer with scalar limit: classifier, command queue and emitter.
// Depends on usp_pkg, usp_front, usp_fifo and usp_back.
//
// Accepts one text byte per cycle whenever the command queue has room, and
// emits one output byte per cycle while the receiver is ready. Plain bytes
// and well-formed sequences stream through the command queue and the
// registered output stage. Each replacement character is three output bytes
// and the end marker one word, so one input byte can yield up to 13 output
// words; meanwhile the classifier keeps accepting until the queue of
// QUEUE_DEPTH commands fills. The scalar limit register is written through
// cfg_valid / cfg_data and must only be changed while the block is idle.
module utf8_sanitize_prefix #(
  parameter int unsigned QUEUE_DEPTH = usp_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // end_of_text
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,   // end_marker
  output logic [1:0]  m_axis_tuser,   // [0] byte_valid, [1] truncated
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data        // max_scalars
);

  logic [15:0]   max_scalars_q;
  logic          push, full, pop, head_valid;
  usp_pkg::cmd_t push_cmd, head_cmd;

  // Hold the scalar limit register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_scalars_q <= usp_pkg::MAX_SCALARS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_scalars_q <= cfg_data;
    end
  end

  usp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .max_scalars_i (max_scalars_q),
    .push_o        (push),
    .cmd_o         (push_cmd),
    .full_i        (full)
  );

  usp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_cmd),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_cmd)
  );

  usp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head_cmd),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

@@ test/utf8_sanitize_prefix_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for utf8_sanitize_prefix: a directed table, then random texts
// under several scalar limits, each output word checked against its row or a predictor.
// Depends on usp_pkg and the utf8_sanitize_prefix RTL.
module utf8_sanitize_prefix_test;

  localparam int DRAIN_CYCLES = 24;
  localparam int PHASE_BYTES  = 44;
  localparam int NUM_PHASES   = 7;
  localparam int DIR_ROWS     = 25;
  localparam bit BY_MODEL     = 1'b0;
  localparam bit TYPED        = 1'b1;

  // One output word as seen on the master side
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_marker;
    logic       truncated;
  } word_t;

  // One input word plus an optional hand-written expectation
  typedef struct packed {
    logic [7:0]      in_byte;
    logic            last;
    logic            typed;
    logic [1:0]      n_bytes;
    logic [2:0][7:0] exp_bytes;
    logic            trunc;
  } stim_t;

  // Kinds of text fragment for the random part
  typedef enum int {
    PC_ASCII, PC_TWO, PC_THREE, PC_FOUR,
    PC_STRAY, PC_BADLEAD, PC_OVERLONG, PC_SURROGATE, PC_TOOBIG, PC_SHORT, PC_ANY
  } piece_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data      = 16'h0000;

  // Predictor state
  logic [15:0] limit_reg = usp_pkg::MAX_SCALARS_RESET;
  logic [7:0]  held [3];
  int          held_n    = 0;
  int          want_len  = 0;
  logic [15:0] scal_cnt  = 16'h0000;
  logic        cut       = 1'b0;

  word_t       step_words[$];
  word_t       expected_words[$];
  stim_t       pending_bytes[$];
  logic [7:0]  text_bytes[$];

  int err_cnt     = 0;
  int words_in    = 0;
  int words_out   = 0;
  int bytes_sent  = 0;
  int texts_sent  = 0;
  int cut_markers = 0;
  int stall_left  = 0;
  bit quiet       = 1'b0;

  utf8_sanitize_prefix dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] in_byte
    .s_axis_tlast  (s_axis_tlast),   // end_of_text
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] out_byte
    .m_axis_tlast  (m_axis_tlast),   // end_marker
    .m_axis_tuser  (m_axis_tuser),   // [0] byte_valid, [1] truncated
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)        // max_scalars
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic word_t mk_word(logic [7:0] b, logic v, logic m, logic t);
    word_t w;
    w.out_byte   = b;
    w.byte_valid = v;
    w.end_marker = m;
    w.truncated  = t;
    return w;
  endfunction

  function automatic void put_word(logic [7:0] b, logic v, logic m, logic t);
    step_words.insert(step_words.size(), mk_word(b, v, m, t));
  endfunction

  // Test the limit before a scalar begins; latch the cut once reached
  function automatic bit may_open_scalar();
    if (cut) return 1'b0;
    if (scal_cnt >= limit_reg) begin
      cut = 1'b1;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void put_rep();
    put_word(usp_pkg::REP_BYTE0, 1'b1, 1'b0, 1'b0);
    put_word(usp_pkg::REP_BYTE1, 1'b1, 1'b0, 1'b0);
    put_word(usp_pkg::REP_BYTE2, 1'b1, 1'b0, 1'b0);
    scal_cnt = scal_cnt + 16'd1;
  endfunction

  // Turn k held bytes into replacements, one each, while the limit allows
  function automatic void flush_held(int k);
    int i;
    for (i = 0; i < k; i++) begin
      if (!may_open_scalar()) break;
      put_rep();
    end
    held_n   = 0;
    want_len = 0;
  endfunction

  function automatic int lead_len(logic [7:0] b);
    if (!b[7]) return 1;
    if (b[7:5] == 3'b110) return 2;
    if (b[7:4] == 4'b1110) return 3;
    if (b[7:3] == 5'b11110) return 4;
    return 0;
  endfunction

  // Reject overlong forms, surrogates and values past the top of the code space
  function automatic bit seq_ok(logic [3:0][7:0] s, int len);
    logic [20:0] cp;
    case (len)
      2: begin
        cp = {10'd0, s[0][4:0], s[1][5:0]};
        return cp >= 21'h80;
      end
      3: begin
        cp = {5'd0, s[0][3:0], s[1][5:0], s[2][5:0]};
        return cp >= 21'h800 && (cp < 21'hD800 || cp > 21'hDFFF);
      end
      4: begin
        cp = {s[0][2:0], s[1][5:0], s[2][5:0], s[3][5:0]};
        return cp >= 21'h10000 && cp <= usp_pkg::CP_MAX;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void begin_scalar(logic [7:0] b);
    int len;
    if (!may_open_scalar()) return;
    len = lead_len(b);
    if (len == 1) begin
      put_word(b, 1'b1, 1'b0, 1'b0);
      scal_cnt = scal_cnt + 16'd1;
    end else if (len == 0) begin
      put_rep();
    end else begin
      held[0]  = b;
      held_n   = 1;
      want_len = len;
    end
  endfunction

  // Words that one accepted input byte causes, left in step_words
  function automatic void sanitize_byte(logic [7:0] b, logic last);
    logic [3:0][7:0] seq;
    int i;
    step_words.delete();
    if (!cut) begin
      if (held_n == 0) begin
        begin_scalar(b);
      end else if (b[7:6] != 2'b10) begin
        // broken sequence: held bytes first, then the new byte starts over
        flush_held(held_n);
        begin_scalar(b);
      end else if (held_n + 1 >= want_len) begin
        seq = '0;
        for (i = 0; i < held_n; i++) seq[i] = held[i];
        seq[held_n] = b;
        if (seq_ok(seq, held_n + 1)) begin
          for (i = 0; i <= held_n; i++) put_word(seq[i], 1'b1, 1'b0, 1'b0);
          scal_cnt = scal_cnt + 16'd1;
          held_n   = 0;
          want_len = 0;
        end else begin
          flush_held(held_n + 1);
        end
      end else if (held_n < 3) begin
        held[held_n] = b;
        held_n++;
      end
    end
    if (last) begin
      // flush an incomplete tail, then the bare marker
      if (held_n > 0 && !cut) flush_held(held_n);
      put_word(8'h00, 1'b0, 1'b1, cut);
      held_n   = 0;
      want_len = 0;
      scal_cnt = 16'h0000;
      cut      = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, logic [7:0] got_v, logic [7:0] want_v);
    err_cnt++;
    $display("%0t ns: %s: got %0h, expected %0h (output word %0d)",
             $time, what, got_v, want_v, words_out);
  endtask

  // Track the limit register, predict each accepted byte, check each output word
  always @(posedge clk_i) begin : monitor
    stim_t s;
    word_t got;
    word_t want;
    int    i;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) limit_reg = cfg_data;

      if (s_axis_tvalid && s_axis_tready && pending_bytes.size() != 0) begin
        s = pending_bytes.pop_front();
        words_in++;
        sanitize_byte(s.in_byte, s.last);
        if (s.typed) begin
          for (i = 0; i < s.n_bytes; i++)
            expected_words.insert(expected_words.size(),
                                  mk_word(s.exp_bytes[i], 1'b1, 1'b0, 1'b0));
          if (s.last)
            expected_words.insert(expected_words.size(),
                                  mk_word(8'h00, 1'b0, 1'b1, s.trunc));
        end else begin
          for (i = 0; i < step_words.size(); i++)
            expected_words.insert(expected_words.size(), step_words[i]);
        end
      end

      if (m_axis_tvalid && m_axis_tready) begin
        got = mk_word(m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]);
        words_out++;
        if (got.end_marker && got.truncated) cut_markers++;
        if (expected_words.size() == 0) begin
          report_mismatch("output word with nothing expected", got.out_byte, 8'h00);
        end else begin
          want = expected_words.pop_front();
          if (got.out_byte != want.out_byte)
            report_mismatch("out_byte", got.out_byte, want.out_byte);
          if (got.byte_valid != want.byte_valid)
            report_mismatch("byte_valid", got.byte_valid, want.byte_valid);
          if (got.end_marker != want.end_marker)
            report_mismatch("end_marker", got.end_marker, want.end_marker);
          if (got.truncated != want.truncated)
            report_mismatch("truncated", got.truncated, want.truncated);
        end
      end
    end
  end

  // Receiver stalls in random bursts, none in the quiet phase
  always @(posedge clk_i) begin : sink_stall
    if (!quiet && stall_left == 0 && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 5);
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic stim_t row(logic [7:0] b, logic last, bit typed, int n,
                                logic [7:0] e0, logic [7:0] e1, logic [7:0] e2, logic tr);
    stim_t s;
    s              = '0;
    s.in_byte      = b;
    s.last         = last;
    s.typed        = typed;
    s.n_bytes      = n[1:0];
    s.exp_bytes[0] = e0;
    s.exp_bytes[1] = e1;
    s.exp_bytes[2] = e2;
    s.trunc        = tr;
    return s;
  endfunction

  function automatic logic [7:0] pick(int lo, int hi);
    return 8'($urandom_range(lo, hi));
  endfunction

  // Append one byte to the text under construction
  function automatic void add_byte(logic [7:0] b);
    text_bytes.insert(text_bytes.size(), b);
  endfunction

  // Append one fragment: mostly well-formed scalars, the rest broken forms and noise
  function automatic void add_piece();
    piece_e     kind;
    int         r;
    logic [7:0] lead;
    r = $urandom_range(0, 99);
    if (r < 35)      kind = PC_ASCII;
    else if (r < 50) kind = PC_TWO;
    else if (r < 62) kind = PC_THREE;
    else if (r < 72) kind = PC_FOUR;
    else             kind = piece_e'($urandom_range(PC_STRAY, PC_ANY));
    case (kind)
      PC_ASCII: add_byte(pick(8'h00, 8'h7F));
      PC_TWO: begin
        add_byte(pick(8'hC2, 8'hDF));
        add_byte(pick(8'h80, 8'hBF));
      end
      PC_THREE: begin
        lead = pick(8'hE0, 8'hEF);
        add_byte(lead);
        if (lead == 8'hE0)      add_byte(pick(8'hA0, 8'hBF));
        else if (lead == 8'hED) add_byte(pick(8'h80, 8'h9F));
        else                    add_byte(pick(8'h80, 8'hBF));
        add_byte(pick(8'h80, 8'hBF));
      end
      PC_FOUR: begin
        lead = pick(8'hF0, 8'hF4);
        add_byte(lead);
        if (lead == 8'hF0)      add_byte(pick(8'h90, 8'hBF));
        else if (lead == 8'hF4) add_byte(pick(8'h80, 8'h8F));
        else                    add_byte(pick(8'h80, 8'hBF));
        add_byte(pick(8'h80, 8'hBF));
        add_byte(pick(8'h80, 8'hBF));
      end
      PC_STRAY:   add_byte(pick(8'h80, 8'hBF));
      PC_BADLEAD: add_byte(pick(8'hF8, 8'hFF));
      PC_OVERLONG: begin
        case ($urandom_range(0, 2))
          0: begin
            add_byte(pick(8'hC0, 8'hC1));
          end
          1: begin
            add_byte(8'hE0);
            add_byte(pick(8'h80, 8'h9F));
          end
          default: begin
            add_byte(8'hF0);
            add_byte(pick(8'h80, 8'h8F));
            add_byte(pick(8'h80, 8'hBF));
          end
        endcase
        add_byte(pick(8'h80, 8'hBF));
      end
      PC_SURROGATE: begin
        add_byte(8'hED);
        add_byte(pick(8'hA0, 8'hBF));
        add_byte(pick(8'h80, 8'hBF));
      end
      PC_TOOBIG: begin
        if ($urandom_range(0, 1) == 0) begin
          add_byte(8'hF4);
          add_byte(pick(8'h90, 8'hBF));
        end else begin
          add_byte(pick(8'hF5, 8'hF7));
          add_byte(pick(8'h80, 8'hBF));
        end
        add_byte(pick(8'h80, 8'hBF));
        add_byte(pick(8'h80, 8'hBF));
      end
      PC_SHORT: begin
        // lead with too few continuations; the next fragment usually breaks it
        case ($urandom_range(0, 2))
          0: add_byte(pick(8'hC2, 8'hDF));
          1: begin
            add_byte(pick(8'hE1, 8'hEC));
            add_byte(pick(8'h80, 8'hBF));
          end
          default: begin
            add_byte(pick(8'hF1, 8'hF3));
            add_byte(pick(8'h80, 8'hBF));
            if ($urandom_range(0, 1) == 0) add_byte(pick(8'h80, 8'hBF));
          end
        endcase
      end
      default: add_byte(pick(8'h00, 8'hFF));
    endcase
  endfunction

  // Drive one word, with an occasional idle burst before it; return once accepted
  task automatic send_word(stim_t s);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    pending_bytes.insert(pending_bytes.size(), s);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s.in_byte;
    s_axis_tlast  <= s.last;
    bytes_sent++;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_text();
    int    pieces;
    int    i;
    stim_t s;
    text_bytes.delete();
    pieces = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 6);
    for (i = 0; i < pieces; i++) add_piece();
    for (i = 0; i < text_bytes.size(); i++) begin
      s         = '0;
      s.in_byte = text_bytes[i];
      s.last    = (i == text_bytes.size() - 1);
      send_word(s);
    end
    texts_sent++;
  endtask

  // Hold the input until every expected word is out, then let the pipe settle
  task automatic drain_out();
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0 || pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    stim_t       dir [DIR_ROWS];
    logic [15:0] limits [NUM_PHASES];
    int          ph;
    int          i;
    int          phase_start;

    // Limit stays at its reset value of 20 for the whole table
    dir[0]  = row(8'h41, 1'b0, TYPED, 1, 8'h41, 8'h00, 8'h00, 1'b0);
    dir[1]  = row(8'h00, 1'b0, TYPED, 1, 8'h00, 8'h00, 8'h00, 1'b0);
    dir[2]  = row(8'h7F, 1'b0, TYPED, 1, 8'h7F, 8'h00, 8'h00, 1'b0);
    // stray continuation and invalid leads: one replacement each
    dir[3]  = row(8'h80, 1'b0, TYPED, 3, usp_pkg::REP_BYTE0, usp_pkg::REP_BYTE1,
                  usp_pkg::REP_BYTE2, 1'b0);
    dir[4]  = row(8'hFF, 1'b0, TYPED, 3, usp_pkg::REP_BYTE0, usp_pkg::REP_BYTE1,
                  usp_pkg::REP_BYTE2, 1'b0);
    dir[5]  = row(8'hF8, 1'b0, TYPED, 3, usp_pkg::REP_BYTE0, usp_pkg::REP_BYTE1,
                  usp_pkg::REP_BYTE2, 1'b0);
    // well-formed two-byte scalar
    dir[6]  = row(8'hC3, 1'b0, TYPED, 0, 8'h00, 8'h00, 8'h00, 1'b0);
    dir[7]  = row(8'hA9, 1'b0, TYPED, 2, 8'hC3, 8'hA9, 8'h00, 1'b0);
    // overlong two-byte form
    dir[8]  = row(8'hC0, 1'b0, TYPED, 0, 8'h00, 8'h00, 8'h00, 1'b0);
    dir[9]  = row(8'h80, 1'b0, BY_MODEL, 0, 8'h00, 8'h00, 8'h00, 1'b0);
    // surrogate
    dir[10] = row(8'hED, 1'b0, TYPED, 0, 8'h00, 8'h00, 8'h00, 1'b0);
    dir[11] = row(8'hA0, 1'b0, TYPED, 0, 8'h00, 8'h00, 8'h00, 1'b0);
    dir[12] = row(8'h80, 1'b0, BY_MODEL, 0, 8'h00, 8'h00, 8'h00, 1'b0);
    // just past the top of the code space
    dir[13] = row(8'hF4, 1'b0, TYPED, 0, 8'h00, 8'h00, 8'h00, 1'b0);
    dir[14] = row(8'h90, 1'b0, TYPED, 0, 8'h00, 8'h00, 8'h00, 1'b0);
    dir[15] = row(8'h80, 1'b0, TYPED, 0, 8'h00, 8'h00, 8'h00, 1'b0);
    dir[16] = row(8'h80, 1'b0, BY_MODEL, 0, 8'h00, 8'h00, 8'h00, 1'b0);
    // well-formed four-byte scalar
    dir[17] = row(8'hF0, 1'b0, TYPED, 0, 8'h00, 8'h00, 8'h00, 1'b0);
    dir[18] = row(8'h9F, 1'b0, TYPED, 0, 8'h00, 8'h00, 8'h00, 1'b0);
    dir[19] = row(8'h98, 1'b0, TYPED, 0, 8'h00, 8'h00, 8'h00, 1'b0);
    dir[20] = row(8'h80, 1'b0, BY_MODEL, 0, 8'h00, 8'h00, 8'h00, 1'b0);
    // broken sequence: a plain byte arrives while two bytes are held
    dir[21] = row(8'hE2, 1'b0, TYPED, 0, 8'h00, 8'h00, 8'h00, 1'b0);
    dir[22] = row(8'h82, 1'b0, TYPED, 0, 8'h00, 8'h00, 8'h00, 1'b0);
    dir[23] = row(8'h41, 1'b0, BY_MODEL, 0, 8'h00, 8'h00, 8'h00, 1'b0);
    // count now sits at the limit: the final lead is dropped, text marked cut
    dir[24] = row(8'hE2, 1'b1, TYPED, 0, 8'h00, 8'h00, 8'h00, 1'b1);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DIR_ROWS; i++) send_word(dir[i]);
    drain_out();

    // Limits from the extremes to a few random small ones
    limits[0] = 16'd0;
    limits[1] = 16'd1;
    limits[2] = 16'd3;
    limits[3] = 16'hFFFF;
    limits[4] = 16'($urandom_range(2, 12));
    limits[5] = usp_pkg::MAX_SCALARS_RESET;
    limits[6] = 16'($urandom_range(0, 40));

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      quiet = (ph == NUM_PHASES - 1);
      write_limit(limits[ph]);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) send_text();
      drain_out();
    end

    $display("Summary: %0d input bytes in %0d random texts plus the directed table, %0d limits",
             words_in, texts_sent, NUM_PHASES);
    $display("Summary: %0d output words checked, %0d truncated markers, %0d mismatches",
             words_out, cut_markers, err_cnt);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("Timeout with %0d words still expected", expected_words.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
